// ===== rtl/bitmap_page_allocator_unit_defines.svh =====
// Assertion macros shared by the page allocator checkers.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("page allocator: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("page allocator: next-cycle property violated");

`endif

// ===== rtl/bpa_pkg.sv =====
// Shared types, codes and helpers of the bitmap page allocator.
// No dependencies; the controller, datapath, top level and checker import this package.
package bpa_pkg;

  localparam int unsigned MAX_PAGES_DEF = 65536;

  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET   = 17'h10000;
  localparam logic [WORD_W-1:0]  WORD_ALL_USED = '1;

  // Input mode codes; the fourth code leaves the map alone and is answered with done
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_TOTAL_PAGES = 1'b0;

  typedef enum logic [1:0] {
    STATUS_DONE         = 2'd0,
    STATUS_NO_FREE      = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic setup;
    logic scan;
    logic enc;
    logic alloc;
    logic mask;
    logic rd;
    logic wr;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic mode_alloc;
    logic mode_range;
    logic found;
    logic none;
    logic skip;
    logic range_last;
    logic out_free;
  } sts_t;

  // Index of the lowest clear bit; 63 when every bit is set
  function automatic logic [5:0] lowest_zero(input logic [WORD_W-1:0] word);
    logic [5:0] idx;
    idx = 6'd63;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/bpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bpa_ctrl.sv =====
// Sequencing state machine of the page allocator: clearing pass, scan, range walk.
// Depends on bpa_pkg for the command and status structs.
module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t cmd_o
);
  import bpa_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_SETUP  = 10'b00_0000_0100,
    S_SCAN   = 10'b00_0000_1000,
    S_ENC    = 10'b00_0001_0000,
    S_ALLOC  = 10'b00_0010_0000,
    S_MASK   = 10'b00_0100_0000,
    S_RRD    = 10'b00_1000_0000,
    S_RWR    = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        if (sts_i.mode_alloc) begin
          state_d = S_SCAN;
        end else if (sts_i.mode_range) begin
          state_d = S_MASK;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.found) begin
          state_d = S_ENC;
        end else if (sts_i.none) begin
          state_d = S_FINISH;
        end
      end
      S_ENC: begin
        cmd_o.enc = 1'b1;
        state_d   = S_ALLOC;
      end
      S_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = S_FINISH;
      end
      S_MASK: begin
        cmd_o.mask = 1'b1;
        // start out of range or empty run: leave the map alone
        state_d = sts_i.skip ? S_FINISH : S_RRD;
      end
      S_RRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_RWR;
      end
      S_RWR: begin
        cmd_o.wr = 1'b1;
        state_d  = sts_i.range_last ? S_FINISH : S_RRD;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/bpa_dp.sv =====
// Datapath of the page allocator: used-bit map RAM, word counter, masks, result registers.
// Depends on bpa_pkg and bpa_ram.
module bpa_dp #(
  parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpa_pkg::cmd_t                 cmd_i,
  output bpa_pkg::sts_t                 sts_o,
  input  logic [bpa_pkg::TOTAL_W-1:0]   total_pages_i,
  input  logic [bpa_pkg::MODE_W-1:0]    mode_i,
  input  logic [bpa_pkg::PAGE_W-1:0]    start_page_i,
  input  logic [bpa_pkg::COUNT_W-1:0]   page_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [bpa_pkg::PAGE_W-1:0]    page_index_o
);
  import bpa_pkg::*;

  localparam int unsigned WORDS = (MAX_PAGES + 63) / 64;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PG_W  = ($clog2(MAX_PAGES + 1) > 18) ? $clog2(MAX_PAGES + 1) : 18;
  localparam int unsigned WN_W  = PG_W - 5;

  // item and derived run
  logic [MODE_W-1:0]  mode_q;
  logic [PAGE_W-1:0]  start_q;
  logic [COUNT_W-1:0] count_q;
  logic [PG_W-1:0]    limit_q, end_q;
  logic               oor_q, zero_q;
  logic [WN_W-1:0]    nwords_q, fw_q, lw_q;
  logic [WORD_W-1:0]  lo_mask_q, hi_mask_q;
  // scan
  logic [WN_W-1:0]    w_q, chk_w_q;
  logic               chk_valid_q;
  logic [WORD_W-1:0]  word_q;
  logic [5:0]         bit_q;
  // results
  status_e            res_status_q, out_status_q;
  logic [PAGE_W-1:0]  res_index_q, out_index_q;
  logic               out_valid_q;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [PG_W-1:0]    total_ext, max_ext, limit_d, run_sum, end_d, end_m1, page;
  logic [PG_W:0]      lim_p63;
  logic               is_range, more, found, none, page_ok, oor_d, reserve;
  logic [WORD_W-1:0]  run_mask, merged;

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign total_ext = PG_W'(total_pages_i);
  assign max_ext   = PG_W'(MAX_PAGES);
  assign limit_d   = (total_ext > max_ext) ? max_ext : total_ext;

  assign is_range = (mode_q == MODE_RELEASE) || (mode_q == MODE_RESERVE);
  assign reserve  = (mode_q == MODE_RESERVE);
  assign run_sum  = PG_W'(start_q) + PG_W'(count_q);
  assign end_d    = (run_sum > limit_q) ? limit_q : run_sum;
  assign oor_d    = PG_W'(start_q) >= limit_q;
  assign lim_p63  = {1'b0, limit_q} + (PG_W + 1)'(63);
  assign end_m1   = end_q - PG_W'(1);

  assign more  = w_q < nwords_q;
  assign found = chk_valid_q && (ram_rdata != WORD_ALL_USED);
  assign none  = !chk_valid_q && !more;

  assign page    = {chk_w_q[WN_W-2:0], bit_q};
  assign page_ok = page < limit_q;

  assign run_mask = ((w_q == fw_q) ? lo_mask_q : WORD_ALL_USED)
                  & ((w_q == lw_q) ? hi_mask_q : WORD_ALL_USED);
  assign merged   = reserve ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd_i.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = w_q[AW-1:0];
      ram_wdata = WORD_ALL_USED;
    end
    if (cmd_i.alloc && page_ok) begin
      ram_we    = 1'b1;
      ram_waddr = chk_w_q[AW-1:0];
      ram_wdata = word_q | (WORD_W'(1) << bit_q);
    end
    if (cmd_i.wr) begin
      ram_we    = 1'b1;
      ram_waddr = w_q[AW-1:0];
      ram_wdata = merged;
    end
    if (cmd_i.scan && !found && more) begin
      ram_re    = 1'b1;
      ram_raddr = w_q[AW-1:0];
    end
    if (cmd_i.rd) begin
      ram_re    = 1'b1;
      ram_raddr = w_q[AW-1:0];
    end
  end

  // control: word counter, pending scan read, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr || cmd_i.wr) begin
        w_q <= w_q + WN_W'(1);
      end else if (cmd_i.setup) begin
        w_q <= (mode_q == MODE_ALLOC) ? '0 : WN_W'(start_q[PAGE_W-1:6]);
      end else if (cmd_i.scan && !found && more) begin
        w_q <= w_q + WN_W'(1);
      end

      if (cmd_i.setup) begin
        chk_valid_q <= 1'b0;
      end else if (cmd_i.scan) begin
        chk_valid_q <= !found && more;
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= mode_i;
      start_q <= start_page_i;
      count_q <= page_count_i;
      limit_q <= limit_d;
    end
    if (cmd_i.setup) begin
      end_q        <= end_d;
      oor_q        <= oor_d;
      zero_q       <= (count_q == '0);
      nwords_q     <= lim_p63[PG_W:6];
      res_index_q  <= '0;
      res_status_q <= (is_range && oor_d) ? STATUS_OUT_OF_RANGE : STATUS_DONE;
    end
    if (cmd_i.scan) begin
      if (found) begin
        word_q <= ram_rdata;
      end else if (more) begin
        chk_w_q <= w_q;
      end else if (none) begin
        res_status_q <= STATUS_NO_FREE;
      end
    end
    if (cmd_i.enc) begin
      bit_q <= lowest_zero(word_q);
    end
    if (cmd_i.alloc) begin
      if (page_ok) begin
        res_status_q <= STATUS_DONE;
        res_index_q  <= page[PAGE_W-1:0];
      end else begin
        res_status_q <= STATUS_NO_FREE;
      end
    end
    if (cmd_i.mask) begin
      fw_q      <= WN_W'(start_q[PAGE_W-1:6]);
      lw_q      <= {1'b0, end_m1[PG_W-1:6]};
      lo_mask_q <= WORD_ALL_USED << start_q[5:0];
      hi_mask_q <= WORD_ALL_USED >> (6'd63 - end_m1[5:0]);
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
    end
  end

  assign sts_o.clr_last   = (w_q == WN_W'(WORDS - 1));
  assign sts_o.mode_alloc = (mode_q == MODE_ALLOC);
  assign sts_o.mode_range = is_range;
  assign sts_o.found      = found;
  assign sts_o.none       = none;
  assign sts_o.skip       = oor_q || zero_q;
  assign sts_o.range_last = (w_q == lw_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign page_index_o = out_index_q;

endmodule

// ===== rtl/bitmap_page_allocator_unit.sv =====
// Top level of the bitmap page allocator: APB register, controller and datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_dp (and through it bpa_ram).
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_ready_o mode_i, start_page_i, page_count_i
//   out      output     out_valid_o/out_ready_i status_o, page_index_o
//   cfg      APB        psel/penable/pready   paddr, pwdata, prdata (total_pages)
//
// One item at a time. Allocate: scans map words up to the first word with a free page,
// all through the single map RAM read port.
// Release/reserve: read-modify-write of each 64-page word touched.
// After reset a clearing pass writes every map word to all-used, during which no item
// is taken; register writes are taken at any time.
// A result waits in the output register while the next item is already being worked on.
module bitmap_page_allocator_unit #(
  parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bpa_pkg::MODE_W-1:0]    mode_i,
  input  logic [bpa_pkg::PAGE_W-1:0]    start_page_i,
  input  logic [bpa_pkg::COUNT_W-1:0]   page_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [bpa_pkg::PAGE_W-1:0]    page_index_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
  input  logic [bpa_pkg::PDATA_W-1:0]   pwdata,
  output logic [bpa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bpa_pkg::*;

  logic [TOTAL_W-1:0] total_q;
  logic               reg_sel;
  cmd_t               cmd;
  sts_t               sts;

  assign reg_sel = (paddr[2] == REG_TOTAL_PAGES);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(PDATA_W - TOTAL_W){1'b0}}, total_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      total_q <= pwdata[TOTAL_W-1:0];
    end
  end

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpa_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .total_pages_i (total_q),
    .mode_i        (mode_i),
    .start_page_i  (start_page_i),
    .page_count_i  (page_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .page_index_o  (page_index_o)
  );

endmodule

// ===== rtl/bpa_checker.sv =====
// Port-level checker of the page allocator, bound to the top level.
// Depends on bpa_pkg and the assertion macros header.
`include "bitmap_page_allocator_unit_defines.svh"

module bpa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 status_o,
  input logic [bpa_pkg::PAGE_W-1:0] page_index_o
);
  import bpa_pkg::*;

  // a stalled result holds
  `BPA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(page_index_o))

  // one item in flight: ready drops right after an accept
  `BPA_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  `BPA_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o, status_o == STATUS_DONE || status_o == STATUS_NO_FREE || status_o == STATUS_OUT_OF_RANGE)

  // failed or rejected items carry no page
  `BPA_ASSERT_NOW(a_index_on_fail, clk_i, rst_ni, out_valid_o && (status_o != STATUS_DONE), page_index_o == '0)

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (.*);
